// ===== rtl/lsrf_pkg.sv =====
// ----------------------------------------------------------------------------
// lsrf_pkg
// Shared sizes, codes and types of the LRU sequence replay filter.
// ----------------------------------------------------------------------------
package lsrf_pkg;

   localparam int ENTRIES  = 16;
   localparam int KEY_BITS = 32;

   localparam int TAG_W   = 32;
   localparam int SEQ_W   = 8;
   localparam int KEY_W   = (KEY_BITS < TAG_W) ? KEY_BITS : TAG_W;
   localparam int ENTRY_W = KEY_W + SEQ_W;
   localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int CNT_W   = $clog2(ENTRIES + 1);
   localparam int CAP_W   = 5;
   localparam int CMP_W   = (CNT_W > CAP_W) ? CNT_W : CAP_W;

   localparam int PADDR_W = 3;
   localparam int PDATA_W = 32;

   localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;
   localparam logic [SEQ_W-1:0] WRAP_HIGH = 8'd240;
   localparam logic [SEQ_W-1:0] WRAP_LOW  = 8'd15;

   localparam logic OP_VALIDATE = 1'b0;
   localparam logic OP_CLEAR    = 1'b1;

   // register index taken from paddr[2]
   localparam logic REG_CAPACITY = 1'b0;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DONE
   } state_type;

endpackage

// ===== rtl/lru_sequence_replay_filter_top.sv =====
// ----------------------------------------------------------------------------
// lru_sequence_replay_filter_top
// Anti-replay filter: key tag to last sequence number, LRU eviction.
// ----------------------------------------------------------------------------
// One item is worked on at a time. Keys and stored sequence numbers sit in a
// single RAM with one read port, scanned one entry per cycle; a validate
// item ends at the first matching entry or, on a miss, after the last one,
// and a clear item skips the scan. Valid bits, LRU ages and the entry count
// live in flip-flops; on a validate they are updated in the same cycle as the
// RAM write-back. The result is held in an output register, so the next item
// is accepted while a result still waits to be taken. The user must write
// capacity only while idle; the block itself does not enforce this.
module lru_sequence_replay_filter_top (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic                         req_opcode,
   input  logic [lsrf_pkg::TAG_W-1:0]   req_key_tag,
   input  logic [lsrf_pkg::SEQ_W-1:0]   req_seq,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic                         rsp_accepted,
   output logic                         rsp_hit,
   output logic                         rsp_evicted,
   input  logic                         psel,
   input  logic                         penable,
   input  logic                         pwrite,
   input  logic [lsrf_pkg::PADDR_W-1:0] paddr,
   input  logic [lsrf_pkg::PDATA_W-1:0] pwdata,
   output logic [lsrf_pkg::PDATA_W-1:0] prdata,
   output logic                         pready
);

   import lsrf_pkg::*;

   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

   state_type state_ff, state_in;

   logic [CAP_W-1:0] cap_ff, cap_in;

   logic               op_ff, op_in;
   logic [KEY_W-1:0]   key_ff, key_in;
   logic [SEQ_W-1:0]   seq_ff, seq_in;

   logic [ENTRIES-1:0] valid_ff, valid_in;
   logic [IDX_W-1:0]   age_ff [ENTRIES];
   logic [IDX_W-1:0]   age_in [ENTRIES];
   logic [CNT_W-1:0]   count_ff, count_in;

   logic [IDX_W-1:0]   iss_ff, iss_in;
   logic               iss_done_ff, iss_done_in;
   logic               chk_vld_ff, chk_vld_in;
   logic [IDX_W-1:0]   chk_idx_ff, chk_idx_in;

   logic res_acc_ff, res_acc_in;
   logic res_hit_ff, res_hit_in;
   logic res_evi_ff, res_evi_in;

   logic rsp_valid_ff, rsp_valid_in;
   logic rsp_acc_ff, rsp_acc_in;
   logic rsp_hit_ff, rsp_hit_in;
   logic rsp_evi_ff, rsp_evi_in;

   logic               ram_wr_en;
   logic [IDX_W-1:0]   ram_wr_addr;
   logic [ENTRY_W-1:0] ram_wr_data;
   logic               ram_rd_en;
   logic [ENTRY_W-1:0] ram_rd_data;

   logic csr_wr;

   lsrf_ram #(
      .WIDTH(ENTRY_W),
      .DEPTH(ENTRIES)
   ) u_entry_ram (
      .clock  (clock),
      .wr_en  (ram_wr_en),
      .wr_addr(ram_wr_addr),
      .wr_data(ram_wr_data),
      .rd_en  (ram_rd_en),
      .rd_addr(iss_ff),
      .rd_data(ram_rd_data)
   );

   // configuration port
   assign pready = 1'b1;
   assign csr_wr = psel && penable && pwrite;
   assign cap_in = (csr_wr && paddr[2] == REG_CAPACITY) ? pwdata[CAP_W-1:0] : cap_ff;
   assign prdata = (paddr[2] == REG_CAPACITY) ? PDATA_W'(cap_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      logic                 accept;
      logic                 key_match;
      logic [SEQ_W-1:0]     last_seq;
      logic                 fresh;
      logic [IDX_W-1:0]     hit_age;
      logic [CMP_W-1:0]     eff_cap;
      logic                 need_evict;
      logic [ENTRIES-1:0]   victim_oh;
      logic [ENTRIES-1:0]   valid_ev;
      logic [IDX_W-1:0]     slot;
      logic                 out_load;

      accept     = req_valid && (state_ff == ST_IDLE);
      key_match  = chk_vld_ff && valid_ff[chk_idx_ff] &&
                   (ram_rd_data[ENTRY_W-1:SEQ_W] == key_ff);
      last_seq   = ram_rd_data[SEQ_W-1:0];
      fresh      = (seq_ff > last_seq) || ((last_seq > WRAP_HIGH) && (seq_ff < WRAP_LOW));
      hit_age    = age_ff[chk_idx_ff];

      if (cap_ff == '0) begin
         eff_cap = CMP_W'(1);
      end else if (CMP_W'(cap_ff) > CMP_W'(ENTRIES)) begin
         eff_cap = CMP_W'(ENTRIES);
      end else begin
         eff_cap = CMP_W'(cap_ff);
      end
      need_evict = CMP_W'(count_ff) >= eff_cap;

      // oldest valid entry carries age count-1
      for (int i = 0; i < ENTRIES; i++) begin
         victim_oh[i] = need_evict && valid_ff[i] &&
                        (CNT_W'(age_ff[i]) == CNT_W'(count_ff - 1'b1));
      end
      valid_ev = valid_ff & ~victim_oh;

      slot = '0;
      for (int i = ENTRIES - 1; i >= 0; i--) begin
         if (!valid_ev[i]) begin
            slot = IDX_W'(i);
         end
      end

      state_in    = state_ff;
      op_in       = op_ff;
      key_in      = key_ff;
      seq_in      = seq_ff;
      valid_in    = valid_ff;
      age_in      = age_ff;
      count_in    = count_ff;
      iss_in      = iss_ff;
      iss_done_in = iss_done_ff;
      chk_vld_in  = 1'b0;
      chk_idx_in  = iss_ff;
      res_acc_in  = res_acc_ff;
      res_hit_in  = res_hit_ff;
      res_evi_in  = res_evi_ff;
      ram_rd_en   = 1'b0;
      ram_wr_en   = 1'b0;
      ram_wr_addr = chk_idx_ff;
      ram_wr_data = {key_ff, seq_ff};
      out_load    = 1'b0;
      req_ready   = (state_ff == ST_IDLE);

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               op_in       = req_opcode;
               key_in      = req_key_tag[KEY_W-1:0];
               seq_in      = req_seq;
               iss_in      = '0;
               iss_done_in = 1'b0;
               if (req_opcode == OP_CLEAR) begin
                  valid_in = '0;
                  for (int i = 0; i < ENTRIES; i++) begin
                     age_in[i] = '0;
                  end
                  count_in   = '0;
                  res_acc_in = 1'b0;
                  res_hit_in = 1'b0;
                  res_evi_in = 1'b0;
                  state_in   = ST_DONE;
               end else begin
                  state_in = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            // issue one read a cycle until the last entry is out
            if (!iss_done_ff) begin
               ram_rd_en   = 1'b1;
               chk_vld_in  = 1'b1;
               iss_done_in = (iss_ff == LAST_IDX);
               if (iss_ff != LAST_IDX) begin
                  iss_in = iss_ff + 1'b1;
               end
            end
            if (key_match) begin
               res_hit_in = 1'b1;
               res_evi_in = 1'b0;
               res_acc_in = fresh;
               if (fresh) begin
                  ram_wr_en   = 1'b1;
                  ram_wr_addr = chk_idx_ff;
                  for (int i = 0; i < ENTRIES; i++) begin
                     if (valid_ff[i] && age_ff[i] < hit_age) begin
                        age_in[i] = age_ff[i] + 1'b1;
                     end
                  end
                  age_in[chk_idx_ff] = '0;
               end
               chk_vld_in = 1'b0;
               state_in   = ST_DONE;
            end else if (chk_vld_ff && chk_idx_ff == LAST_IDX) begin
               // miss: drop the oldest if full, insert at lowest free slot
               ram_wr_en   = 1'b1;
               ram_wr_addr = slot;
               for (int i = 0; i < ENTRIES; i++) begin
                  if (valid_ev[i]) begin
                     age_in[i] = age_ff[i] + 1'b1;
                  end else begin
                     age_in[i] = '0;
                  end
               end
               valid_in       = valid_ev;
               valid_in[slot] = 1'b1;
               count_in       = count_ff - CNT_W'(need_evict) + 1'b1;
               res_hit_in     = 1'b0;
               res_acc_in     = 1'b1;
               res_evi_in     = need_evict;
               chk_vld_in     = 1'b0;
               state_in       = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               out_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      rsp_valid_in = out_load ? 1'b1 : (rsp_valid_ff && !rsp_ready);
      rsp_acc_in   = out_load ? res_acc_ff : rsp_acc_ff;
      rsp_hit_in   = out_load ? res_hit_ff : rsp_hit_ff;
      rsp_evi_in   = out_load ? res_evi_ff : rsp_evi_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff       <= CAP_RESET;
         valid_ff     <= '0;
         count_ff     <= '0;
         chk_vld_ff   <= 1'b0;
         iss_done_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < ENTRIES; i++) begin
            age_ff[i] <= '0;
         end
      end else begin
         cap_ff       <= cap_in;
         valid_ff     <= valid_in;
         count_ff     <= count_in;
         chk_vld_ff   <= chk_vld_in;
         iss_done_ff  <= iss_done_in;
         rsp_valid_ff <= rsp_valid_in;
         age_ff       <= age_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff      <= op_in;
      key_ff     <= key_in;
      seq_ff     <= seq_in;
      iss_ff     <= iss_in;
      chk_idx_ff <= chk_idx_in;
      res_acc_ff <= res_acc_in;
      res_hit_ff <= res_hit_in;
      res_evi_ff <= res_evi_in;
      rsp_acc_ff <= rsp_acc_in;
      rsp_hit_ff <= rsp_hit_in;
      rsp_evi_ff <= rsp_evi_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_accepted = rsp_acc_ff;
   assign rsp_hit      = rsp_hit_ff;
   assign rsp_evicted  = rsp_evi_ff;

   // checks

   a_count_matches_valid: assert property (@(posedge clock) disable iff (reset)
      CNT_W'($countones(valid_ff)) == count_ff)
      else $error("entry count out of step with valid bits");

   a_count_bounded: assert property (@(posedge clock) disable iff (reset)
      CMP_W'(count_ff) <= CMP_W'(ENTRIES))
      else $error("entry count above table size");

   a_clear_empties: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_opcode == OP_CLEAR) |=> (count_ff == '0 && valid_ff == '0))
      else $error("clear item left entries behind");

   a_check_only_in_scan: assert property (@(posedge clock) disable iff (reset)
      chk_vld_ff |-> (state_ff == ST_SCAN && op_ff == OP_VALIDATE))
      else $error("read data check outside a validate scan");

endmodule

// ===== rtl/lsrf_ram.sv =====
// ----------------------------------------------------------------------------
// lsrf_ram
// Generic single-write, single-read synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module lsrf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== tb/lru_sequence_replay_filter_top_tb.sv =====
// ----------------------------------------------------------------------------
// lru_sequence_replay_filter_top_tb
// Self-checking bench for the LRU anti-replay sequence table. A small
// scoreboard keeps its own copy of the tag table, ages and capacity, works
// out the verdict of every accepted item and compares it with the block's
// results in order. Stimulus runs a directed opening, then phases of
// per-key sequence traffic with replays, wraps, clears and noise, under
// several capacity settings and idling patterns.
// ----------------------------------------------------------------------------
module lru_sequence_replay_filter_top_tb;
   import lsrf_pkg::*;

   typedef struct packed {
      logic accepted;
      logic hit;
      logic evicted;
   } verdict_type;

   class replay_verdict_board;
      logic [KEY_W-1:0] tag_store [ENTRIES];
      logic [SEQ_W-1:0] seq_store [ENTRIES];
      bit               live_store [ENTRIES];
      int unsigned      age_store [ENTRIES];
      int unsigned      live_count;
      logic [CAP_W-1:0] capacity;
      verdict_type      verdicts_due [$];
      int unsigned      mismatches;

      function new();
         foreach (live_store[i]) begin
            live_store[i] = 1'b0;
            age_store[i]  = 0;
         end
         live_count = 0;
         capacity   = CAP_RESET;
         mismatches = 0;
      endfunction

      function void set_capacity(logic [PDATA_W-1:0] word);
         capacity = word[CAP_W-1:0];
      endfunction

      function void note_packet(logic op, logic [TAG_W-1:0] tag, logic [SEQ_W-1:0] seq);
         verdict_type      v;
         int               slot;
         int               victim;
         int unsigned      limit;
         logic [KEY_W-1:0] key;
         logic [SEQ_W-1:0] last;
         v      = '0;
         slot   = -1;
         victim = -1;
         key    = tag[KEY_W-1:0];
         if (op == OP_CLEAR) begin
            foreach (live_store[i]) begin
               live_store[i] = 1'b0;
               age_store[i]  = 0;
            end
            live_count = 0;
            verdicts_due.push_back(v);
            return;
         end
         for (int i = 0; i < ENTRIES; i++)
            if (slot < 0 && live_store[i] && tag_store[i] == key) slot = i;
         if (slot >= 0) begin
            v.hit = 1'b1;
            last  = seq_store[slot];
            // newer, or a wrap from the top of the range to the bottom
            if (seq > last || (last > WRAP_HIGH && seq < WRAP_LOW)) begin
               v.accepted      = 1'b1;
               seq_store[slot] = seq;
               for (int i = 0; i < ENTRIES; i++)
                  if (live_store[i] && age_store[i] < age_store[slot]) age_store[i]++;
               age_store[slot] = 0;
            end
            verdicts_due.push_back(v);
            return;
         end
         limit = 32'(capacity);
         if (limit < 1) limit = 1;
         if (limit > ENTRIES) limit = ENTRIES;
         // a miss drops one entry at most, even with capacity lowered below count
         if (live_count >= limit) begin
            for (int i = 0; i < ENTRIES; i++)
               if (live_store[i] && (victim < 0 || age_store[i] > age_store[victim]))
                  victim = i;
            if (victim >= 0) begin
               live_store[victim] = 1'b0;
               age_store[victim]  = 0;
               live_count--;
               v.evicted = 1'b1;
            end
         end
         for (int i = 0; i < ENTRIES; i++)
            if (slot < 0 && !live_store[i]) slot = i;
         for (int i = 0; i < ENTRIES; i++)
            if (live_store[i]) age_store[i]++;
         tag_store[slot]  = key;
         seq_store[slot]  = seq;
         live_store[slot] = 1'b1;
         age_store[slot]  = 0;
         live_count++;
         v.accepted = 1'b1;
         verdicts_due.push_back(v);
      endfunction

      task flag_mismatch(string what);
         $display("MISMATCH at %0t: %s", $time, what);
         mismatches++;
      endtask

      task check_verdict(verdict_type got);
         verdict_type want;
         if (verdicts_due.size() == 0) begin
            flag_mismatch($sformatf("result %b/%b/%b with no item outstanding",
                                    got.accepted, got.hit, got.evicted));
            return;
         end
         want = verdicts_due.pop_front();
         if (got.accepted !== want.accepted)
            flag_mismatch($sformatf("accepted %b, want %b", got.accepted, want.accepted));
         if (got.hit !== want.hit)
            flag_mismatch($sformatf("hit %b, want %b", got.hit, want.hit));
         if (got.evicted !== want.evicted)
            flag_mismatch($sformatf("evicted %b, want %b", got.evicted, want.evicted));
      endtask
   endclass

   logic               clock;
   logic               reset       = 1'b1;
   logic               req_valid   = 1'b0;
   logic               req_ready;
   logic               req_opcode  = OP_VALIDATE;
   logic [TAG_W-1:0]   req_key_tag = '0;
   logic [SEQ_W-1:0]   req_seq     = '0;
   logic               rsp_valid;
   logic               rsp_ready   = 1'b0;
   logic               rsp_accepted;
   logic               rsp_hit;
   logic               rsp_evicted;
   logic               psel        = 1'b0;
   logic               penable     = 1'b0;
   logic               pwrite      = 1'b0;
   logic [PADDR_W-1:0] paddr       = '0;
   logic [PDATA_W-1:0] pwdata      = '0;
   logic [PDATA_W-1:0] prdata;
   logic               pready;

   replay_verdict_board board = new();

   int unsigned send_idle_pct = 0;
   int unsigned recv_idle_pct = 0;
   bit          hold_off_req  = 1'b0;

   logic [TAG_W-1:0] pool_tag [24];
   logic [SEQ_W-1:0] pool_seq [24];

   lru_sequence_replay_filter_top u_top (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_opcode   (req_opcode),
      .req_key_tag  (req_key_tag),
      .req_seq      (req_seq),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_accepted (rsp_accepted),
      .rsp_hit      (rsp_hit),
      .rsp_evicted  (rsp_evicted),
      .psel         (psel),
      .penable      (penable),
      .pwrite       (pwrite),
      .paddr        (paddr),
      .pwdata       (pwdata),
      .prdata       (prdata),
      .pready       (pready)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // slowest run: ~1100 items plus stalls, taken many times over
   initial begin
      #4800000;
      $display("lru_sequence_replay_filter_top_tb NOT OK");
      $finish;
   end

   // result side: check on handshake, then pick ready for the next cycle
   initial begin
      int unsigned hold_left;
      verdict_type got;
      hold_left = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && rsp_ready) begin
            got = {rsp_accepted, rsp_hit, rsp_evicted};
            board.check_verdict(got);
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else if (hold_off_req) begin
            hold_off_req = 1'b0;
            hold_left    = 90;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
         end
      end
   end

   task automatic send_packet(input logic op, input logic [TAG_W-1:0] tag,
                              input logic [SEQ_W-1:0] seq);
      int unsigned gap;
      if ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         gap = $urandom_range(1, 6);
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_opcode  <= op;
      req_key_tag <= tag;
      req_seq     <= seq;
      do @(posedge clock); while (!req_ready);
      board.note_packet(op, tag, seq);
   endtask

   // drop valid, wait for every verdict, then let the block settle
   task automatic wait_until_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (board.verdicts_due.size() != 0);
      repeat (24) @(posedge clock);
   endtask

   task automatic write_capacity(input logic [CAP_W-1:0] cap);
      logic [PDATA_W-1:0] word;
      word            = $urandom;
      word[CAP_W-1:0] = cap;
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {REG_CAPACITY, 2'b00};
      pwdata  <= word;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      board.set_capacity(word);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   initial begin
      int unsigned      phase_cap [8];
      int unsigned      phase_span [8];
      int unsigned      roll;
      int unsigned      idx;
      logic             op;
      logic [TAG_W-1:0] tag;
      logic [SEQ_W-1:0] seq;

      phase_cap  = '{16, 3, 0, 31, 1, 8, 17, 0};
      phase_span = '{20, 6, 3, 24, 2, 12, 20, 0};
      phase_cap[7]  = $urandom_range(0, 31);
      phase_span[7] = $urandom_range(2, 24);
      pool_tag[0] = '0;
      pool_tag[1] = '1;
      pool_seq[0] = '0;
      pool_seq[1] = '0;
      for (int i = 2; i < 24; i++) begin
         pool_tag[i] = $urandom;
         pool_seq[i] = 8'($urandom);
      end

      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: equal, newer, wrap, near-wrap and clear at reset capacity
      send_packet(OP_VALIDATE, 32'h0000_0000, 8'd0);
      send_packet(OP_VALIDATE, 32'h0000_0000, 8'd0);
      send_packet(OP_VALIDATE, 32'h0000_0000, 8'd255);
      send_packet(OP_VALIDATE, 32'h0000_0000, 8'd14);
      send_packet(OP_VALIDATE, 32'h0000_0000, 8'd14);
      send_packet(OP_VALIDATE, 32'hFFFF_FFFF, 8'd241);
      send_packet(OP_VALIDATE, 32'hFFFF_FFFF, 8'd15);
      send_packet(OP_VALIDATE, 32'hFFFF_FFFF, 8'd0);
      send_packet(OP_VALIDATE, 32'hA5A5_5A5A, 8'd240);
      send_packet(OP_VALIDATE, 32'hA5A5_5A5A, 8'd5);
      send_packet(OP_VALIDATE, 32'hA5A5_5A5A, 8'd239);
      send_packet(OP_VALIDATE, 32'hA5A5_5A5A, 8'd241);
      send_packet(OP_CLEAR,    32'h1234_5678, 8'd77);
      send_packet(OP_VALIDATE, 32'h0000_0000, 8'd200);
      send_packet(OP_CLEAR,    32'hFFFF_FFFF, 8'd255);
      wait_until_drained();

      // single-entry table: each new key after the first evicts
      write_capacity(5'd1);
      send_packet(OP_VALIDATE, 32'h0000_0001, 8'd1);
      send_packet(OP_VALIDATE, 32'h0000_0002, 8'd1);
      send_packet(OP_VALIDATE, 32'h0000_0002, 8'd2);
      send_packet(OP_VALIDATE, 32'h0000_0001, 8'd9);
      wait_until_drained();

      // zero capacity behaves as one
      write_capacity(5'd0);
      send_packet(OP_VALIDATE, 32'h0000_0003, 8'd0);
      send_packet(OP_VALIDATE, 32'h0000_0003, 8'd0);
      send_packet(OP_VALIDATE, 32'h0000_0004, 8'd128);
      wait_until_drained();

      // table contents carry over, so lower capacities can start below the count
      for (int ph = 0; ph < 8; ph++) begin
         write_capacity(phase_cap[ph][CAP_W-1:0]);
         if (ph < 3) begin
            send_idle_pct = 26;
            recv_idle_pct = 67;
         end else if (ph < 6) begin
            send_idle_pct = 67;
            recv_idle_pct = 26;
         end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         for (int n = 0; n < 130; n++) begin
            if ((ph == 1 && n == 50) || (ph == 6 && n == 30)) hold_off_req = 1'b1;
            roll = $urandom_range(0, 99);
            idx  = $urandom_range(0, phase_span[ph] - 1);
            op   = OP_VALIDATE;
            tag  = pool_tag[idx];
            seq  = pool_seq[idx];
            if (roll < 3) begin
               op  = OP_CLEAR;
               tag = $urandom;
               seq = 8'($urandom);
            end else if (roll < 13) begin
               tag = $urandom;
               seq = 8'($urandom);
            end else if (roll < 65) begin
               // advance the key's sequence, wrapping past 255 now and then
               seq           = pool_seq[idx] + 8'($urandom_range(1, 20));
               pool_seq[idx] = seq;
            end else if (roll < 85) begin
               seq = pool_seq[idx] - 8'($urandom_range(0, 5));
            end else begin
               seq = 8'($urandom);
            end
            send_packet(op, tag, seq);
         end
         wait_until_drained();
      end

      if (board.mismatches == 0 && board.verdicts_due.size() == 0)
         $display("lru_sequence_replay_filter_top_tb OK");
      else
         $display("lru_sequence_replay_filter_top_tb NOT OK");
      $finish;
   end

endmodule

// ===== lru_sequence_replay_filter_top.f =====
rtl/lsrf_pkg.sv
rtl/lsrf_ram.sv
rtl/lru_sequence_replay_filter_top.sv
tb/lru_sequence_replay_filter_top_tb.sv
